/* hdl/tun_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the triangle unit normal block
// no dependencies
package tun_pkg;

	localparam int OUT_WIDTH = 16;
	localparam int SAT_WIDTH = 32;
	localparam logic [SAT_WIDTH-1:0] POS_LIMIT = 32'd32767;
	localparam logic [SAT_WIDTH-1:0] NEG_LIMIT = 32'd32768;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] x;
		logic signed [OUT_WIDTH-1:0] y;
		logic signed [OUT_WIDTH-1:0] z;
		logic                        nv;
	} result_t;

endpackage

/* hdl/tun_in_if.sv */
`timescale 1ns / 1ps
// vertex channel: three triangle vertices, valid/ready handshake
// no dependencies
interface tun_in_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] vertex_a_x, vertex_a_y, vertex_a_z;
	logic signed [COORD_WIDTH-1:0] vertex_b_x, vertex_b_y, vertex_b_z;
	logic signed [COORD_WIDTH-1:0] vertex_c_x, vertex_c_y, vertex_c_z;

	modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z,
		vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
		input ready);
	modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z,
		vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
		output ready);
endinterface

/* hdl/tun_out_if.sv */
`timescale 1ns / 1ps
// normal channel: unit normal and valid flag, valid/ready handshake
// depends on tun_pkg
interface tun_out_if;
	logic valid;
	logic ready;
	logic signed [tun_pkg::OUT_WIDTH-1:0] normal_x, normal_y, normal_z;
	logic normal_valid;

	modport source (output valid, normal_x, normal_y, normal_z, normal_valid, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, normal_valid, output ready);
endinterface

/* hdl/triangle_unit_normal.sv */
`timescale 1ns / 1ps
// triangle unit normal: top level with pipeline, sign/saturation and output skid
// depends on tun_pkg, tun_in_if, tun_out_if, tun_cross, tun_sqrt, tun_div
//
// usage:
//   vertices carries one triangle (A, B, C, signed fixed point) per item; normals
//   returns one item per triangle: the unit normal of e2 x e1 (e1 = B - A,
//   e2 = C - A) in signed Q1.NORMAL_FRAC_BITS, truncated toward zero, plus
//   normal_valid, which is 0 (with a zero normal) for a degenerate triangle.
//   from acceptance to normals.valid an item passes eight stages of cross
//   product and squared length, one stage per root bit of the square root,
//   one stage per quotient bit of the three-lane divider and the output register.
//   throughput is one item per cycle while vertices.ready is high; items stay
//   in order.
//   when normals stalls, a result parks in a skid register and the pipeline
//   keeps taking items until that register is occupied; then vertices.ready
//   drops and the whole pipeline holds, losing nothing.
//   reset clears all valid bits; vertices.ready is high right after reset.
module triangle_unit_normal #(
	parameter int COORD_WIDTH = 32,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	tun_in_if.sink    vertices,
	tun_out_if.source normals
);
	localparam int MW  = 2 * COORD_WIDTH + 1;
	localparam int RW  = MW + 1;
	localparam int SW  = 2 * MW + 2;
	localparam int QW  = NORMAL_FRAC_BITS + 1;
	localparam int SAT = tun_pkg::SAT_WIDTH;
	localparam int OW  = tun_pkg::OUT_WIDTH;

	logic en;
	logic out_valid_q, skid_valid_q;
	tun_pkg::result_t out_q, skid_q, res;

	logic          cr_valid;
	logic [SW-1:0] cr_sum;
	logic [MW-1:0] cr_mag [3];
	logic [2:0]    cr_neg;
	logic          sq_valid;
	logic [RW-1:0] sq_root;
	logic [MW-1:0] sq_mag [3];
	logic [2:0]    sq_neg;
	logic          dv_valid, dv_len_zero;
	logic [QW-1:0] dv_quo [3];
	logic [2:0]    dv_neg;

	assign en = !skid_valid_q;
	assign vertices.ready = en;

	tun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
		.clk, .arst_n, .en,
		.vtx   (vertices),
		.valid (cr_valid),
		.sum   (cr_sum),
		.mag   (cr_mag),
		.neg   (cr_neg)
	);

	tun_sqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt (
		.clk, .arst_n, .en,
		.in_valid  (cr_valid),
		.in_sum    (cr_sum),
		.in_mag    (cr_mag),
		.in_neg    (cr_neg),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_mag   (sq_mag),
		.out_neg   (sq_neg)
	);

	tun_div #(.COORD_WIDTH(COORD_WIDTH), .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
		.clk, .arst_n, .en,
		.in_valid     (sq_valid),
		.in_len       (sq_root),
		.in_mag       (sq_mag),
		.in_neg       (sq_neg),
		.out_valid    (dv_valid),
		.out_len_zero (dv_len_zero),
		.out_quo      (dv_quo),
		.out_neg      (dv_neg)
	);

	// sign, saturation to the 16-bit field, zero for a degenerate triangle
	logic [SAT-1:0] qz [3], lim [3], mc [3], sv [3];
	logic [OW-1:0]  comp [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qz[i]   = {{(SAT-QW){1'b0}}, dv_quo[i]};
			lim[i]  = dv_neg[i] ? tun_pkg::NEG_LIMIT : tun_pkg::POS_LIMIT;
			mc[i]   = (qz[i] > lim[i]) ? lim[i] : qz[i];
			sv[i]   = dv_neg[i] ? -mc[i] : mc[i];
			comp[i] = dv_len_zero ? '0 : sv[i][OW-1:0];
		end
		res.x  = $signed(comp[0]);
		res.y  = $signed(comp[1]);
		res.z  = $signed(comp[2]);
		res.nv = !dv_len_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (normals.ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (dv_valid) begin
			if (out_valid_q && !normals.ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (normals.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (normals.ready) begin
				out_q <= skid_q;
			end
		end else if (dv_valid) begin
			if (out_valid_q && !normals.ready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign normals.valid        = out_valid_q;
	assign normals.normal_x     = out_q.x;
	assign normals.normal_y     = out_q.y;
	assign normals.normal_z     = out_q.z;
	assign normals.normal_valid = out_q.nv;

	// a parked item always has one ahead of it in the output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds an item while output register is empty");

	// the pipeline holds while an item is parked
	a_hold_when_parked: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !vertices.ready)
		else $error("input accepted while skid register is occupied");

	// a parked item stays until the receiver takes the output
	a_skid_kept: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !normals.ready |=> skid_valid_q)
		else $error("parked item dropped without a transfer");

	// a degenerate triangle gives a zero normal
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		normals.valid && !normals.normal_valid |->
			normals.normal_x == '0 && normals.normal_y == '0 && normals.normal_z == '0)
		else $error("nonzero normal reported for a degenerate triangle");

endmodule

/* hdl/tun_cross.sv */
`timescale 1ns / 1ps
// edge vectors, cross product, component magnitudes and squared length
// eight pipeline stages; depends on tun_in_if
module tun_cross #(
	parameter int COORD_WIDTH = 32,
	localparam int MW = 2 * COORD_WIDTH + 1,
	localparam int H  = COORD_WIDTH + 1,
	localparam int SW = 2 * MW + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	tun_in_if.sink        vtx,
	output logic          valid,
	output logic [SW-1:0] sum,
	output logic [MW-1:0] mag [3],
	output logic [2:0]    neg
);
	localparam int CW = COORD_WIDTH;

	logic signed [CW-1:0] va [3], vb [3], vc [3];
	logic signed [CW:0]   e1 [3], e2 [3];

	assign va[0] = vtx.vertex_a_x;
	assign va[1] = vtx.vertex_a_y;
	assign va[2] = vtx.vertex_a_z;
	assign vb[0] = vtx.vertex_b_x;
	assign vb[1] = vtx.vertex_b_y;
	assign vb[2] = vtx.vertex_b_z;
	assign vc[0] = vtx.vertex_c_x;
	assign vc[1] = vtx.vertex_c_y;
	assign vc[2] = vtx.vertex_c_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = (CW+1)'(vb[i]) - (CW+1)'(va[i]);
			e2[i] = (CW+1)'(vc[i]) - (CW+1)'(va[i]);
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [CW-1:0]        e1m_s1 [3], e2m_s1 [3];
	logic [2:0]           e1n_s1, e2n_s1;
	logic [2*CW-1:0]      pm_s2 [3], qm_s2 [3];
	logic [2:0]           pn_s2, qn_s2;
	logic signed [2*CW:0] ps_s3 [3], qs_s3 [3];
	logic signed [MW:0]   cr_s4 [3];
	logic [MW-1:0]        mag_s5 [3], mag_s6 [3], mag_s7 [3], mag_s8 [3];
	logic [2:0]           neg_s5, neg_s6, neg_s7, neg_s8;
	logic [2*H-1:0]       hh_s6 [3], hl_s6 [3], ll_s6 [3];
	logic [SW-1:0]        sq_s7 [3];
	logic [SW-1:0]        sum_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{vtx.valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	// magnitudes of the edges, |e| < 2^CW
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1m_s1[i] <= CW'(e1[i][CW] ? -e1[i] : e1[i]);
				e2m_s1[i] <= CW'(e2[i][CW] ? -e2[i] : e2[i]);
				e1n_s1[i] <= e1[i][CW];
				e2n_s1[i] <= e2[i][CW];
			end
		end
	end

	// c = e2 x e1, component g = e2[j]*e1[k] - e2[k]*e1[j]
	for (genvar g = 0; g < 3; g++) begin : g_prod
		localparam int J = (g + 1) % 3;
		localparam int K = (g + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				pm_s2[g] <= (2*CW)'(e2m_s1[J]) * (2*CW)'(e1m_s1[K]);
				qm_s2[g] <= (2*CW)'(e2m_s1[K]) * (2*CW)'(e1m_s1[J]);
				pn_s2[g] <= e2n_s1[J] ^ e1n_s1[K];
				qn_s2[g] <= e2n_s1[K] ^ e1n_s1[J];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ps_s3[i] <= pn_s2[i] ? -$signed({1'b0, pm_s2[i]}) : $signed({1'b0, pm_s2[i]});
				qs_s3[i] <= qn_s2[i] ? -$signed({1'b0, qm_s2[i]}) : $signed({1'b0, qm_s2[i]});
				cr_s4[i] <= (MW+1)'(ps_s3[i]) - (MW+1)'(qs_s3[i]);
				mag_s5[i] <= MW'(cr_s4[i][MW] ? -cr_s4[i] : cr_s4[i]);
				neg_s5[i] <= cr_s4[i][MW];
				// square split into halves of H bits
				hh_s6[i] <= (2*H)'({1'b0, mag_s5[i][MW-1:H]}) * (2*H)'({1'b0, mag_s5[i][MW-1:H]});
				hl_s6[i] <= (2*H)'({1'b0, mag_s5[i][MW-1:H]}) * (2*H)'(mag_s5[i][H-1:0]);
				ll_s6[i] <= (2*H)'(mag_s5[i][H-1:0]) * (2*H)'(mag_s5[i][H-1:0]);
				mag_s6[i] <= mag_s5[i];
				neg_s6[i] <= neg_s5[i];
				sq_s7[i] <= {hh_s6[i], ll_s6[i]} + (SW'(hl_s6[i]) << (H + 1));
				mag_s7[i] <= mag_s6[i];
				neg_s7[i] <= neg_s6[i];
				mag_s8[i] <= mag_s7[i];
				neg_s8[i] <= neg_s7[i];
			end
			sum_s8 <= sq_s7[0] + sq_s7[1] + sq_s7[2];
		end
	end

	assign valid = v_s8;
	assign sum   = sum_s8;
	assign mag   = mag_s8;
	assign neg   = neg_s8;

endmodule

/* hdl/tun_sqrt.sv */
`timescale 1ns / 1ps
// integer square root of the squared length, one result bit per stage
// no dependencies
module tun_sqrt #(
	parameter int COORD_WIDTH = 32,
	localparam int MW = 2 * COORD_WIDTH + 1,
	localparam int RW = MW + 1,
	localparam int SW = 2 * MW + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [SW-1:0] in_sum,
	input  logic [MW-1:0] in_mag [3],
	input  logic [2:0]    in_neg,
	output logic          out_valid,
	output logic [RW-1:0] out_root,
	output logic [MW-1:0] out_mag [3],
	output logic [2:0]    out_neg
);
	logic          v_s    [RW];
	logic [SW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [MW-1:0] mag_s  [RW][3];
	logic [2:0]    neg_s  [RW];

	for (genvar g = 0; g < RW; g++) begin : g_stage
		localparam int B = RW - 1 - g;
		logic          pv;
		logic [SW-1:0] prem;
		logic [RW-1:0] proot;
		logic [MW-1:0] pmag [3];
		logic [2:0]    pneg;
		logic [SW:0]   trial;
		logic          take;

		if (g == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = in_sum;
			assign proot = '0;
			assign pmag  = in_mag;
			assign pneg  = in_neg;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign prem  = rem_s[g-1];
			assign proot = root_s[g-1];
			assign pmag  = mag_s[g-1];
			assign pneg  = neg_s[g-1];
		end

		// (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
		assign trial = ((SW+1)'(proot) << (B + 1)) + ((SW+1)'(1) << (2 * B));
		assign take  = {1'b0, prem} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= take ? SW'({1'b0, prem} - trial) : prem;
				root_s[g] <= take ? (proot | (RW'(1) << B)) : proot;
				mag_s[g]  <= pmag;
				neg_s[g]  <= pneg;
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_mag   = mag_s[RW-1];
	assign out_neg   = neg_s[RW-1];

endmodule

/* hdl/tun_div.sv */
`timescale 1ns / 1ps
// three-lane restoring divider, mag * 2^frac / length, one quotient bit per stage
// no dependencies
module tun_div #(
	parameter int COORD_WIDTH = 32,
	parameter int NORMAL_FRAC_BITS = 14,
	localparam int MW = 2 * COORD_WIDTH + 1,
	localparam int RW = MW + 1,
	localparam int QW = NORMAL_FRAC_BITS + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [RW-1:0] in_len,
	input  logic [MW-1:0] in_mag [3],
	input  logic [2:0]    in_neg,
	output logic          out_valid,
	output logic          out_len_zero,
	output logic [QW-1:0] out_quo [3],
	output logic [2:0]    out_neg
);
	localparam int DW = MW + NORMAL_FRAC_BITS + 2;

	logic          v_s   [QW];
	logic [RW-1:0] len_s [QW];
	logic [DW-1:0] rem_s [QW][3];
	logic [QW-1:0] quo_s [QW][3];
	logic [2:0]    neg_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int B = QW - 1 - g;
		logic          pv;
		logic [RW-1:0] plen;
		logic [DW-1:0] prem [3];
		logic [QW-1:0] pquo [3];
		logic [2:0]    pneg;
		logic [DW-1:0] dv;

		if (g == 0) begin : g_first
			assign pv   = in_valid;
			assign plen = in_len;
			assign pneg = in_neg;
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign prem[i] = DW'(in_mag[i]) << NORMAL_FRAC_BITS;
				assign pquo[i] = '0;
			end
		end else begin : g_next
			assign pv   = v_s[g-1];
			assign plen = len_s[g-1];
			assign prem = rem_s[g-1];
			assign pquo = quo_s[g-1];
			assign pneg = neg_s[g-1];
		end

		assign dv = DW'(plen) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[g] <= plen;
				neg_s[g] <= pneg;
				for (int i = 0; i < 3; i++) begin
					if (prem[i] >= dv) begin
						rem_s[g][i] <= prem[i] - dv;
						quo_s[g][i] <= pquo[i] | (QW'(1) << B);
					end else begin
						rem_s[g][i] <= prem[i];
						quo_s[g][i] <= pquo[i];
					end
				end
			end
		end
	end

	assign out_valid    = v_s[QW-1];
	assign out_len_zero = (len_s[QW-1] == '0);
	assign out_quo      = quo_s[QW-1];
	assign out_neg      = neg_s[QW-1];

endmodule
